FILE: design/rms_pkg.sv
`default_nettype none

package rms_pkg;

    // Default build widths
    localparam int TIME_WIDTH_DEF   = 16;
    localparam int SENSOR_WIDTH_DEF = 10;

    // Fixed field widths
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int ERR_W      = 4;
    localparam int INJ_W      = 16;
    localparam int CFG_TIME_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_IDLE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXECUTING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COMPLETED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ERROR     = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 4'd0;
    localparam logic [ERR_W-1:0] ERR_POSITION  = 4'd1;
    localparam logic [ERR_W-1:0] ERR_PRESS_LO  = 4'd2;
    localparam logic [ERR_W-1:0] ERR_PRESS_HI  = 4'd3;
    localparam logic [ERR_W-1:0] ERR_VOLTAGE   = 4'd4;
    localparam logic [ERR_W-1:0] ERR_AMMO      = 4'd5;
    localparam logic [ERR_W-1:0] ERR_OVERLOAD  = 4'd6;
    localparam logic [ERR_W-1:0] ERR_TIMEOUT   = 4'd7;
    localparam logic [ERR_W-1:0] ERR_INJECTION = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_SPINUP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INJECTION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_FAN         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BREECH_ENGAGE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_MAX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_MIN     = 3'd7;

    // Register reset values
    localparam logic [CFG_TIME_W-1:0] RST_REVERSE_TIMEOUT = 16'd3000;
    localparam logic [CFG_TIME_W-1:0] RST_FAN_SPINUP      = 16'd500;
    localparam logic [CFG_TIME_W-1:0] RST_MAX_INJECTION   = 16'd1000;
    localparam logic [CFG_TIME_W-1:0] RST_MIX_FAN         = 16'd3000;
    localparam logic [CFG_TIME_W-1:0] RST_BREECH_ENGAGE   = 16'd500;

    // Actuator outputs
    typedef struct packed {
        logic breech;
        logic injector;
        logic fan;
        logic loader;
    } act_t;

    localparam act_t ACT_OFF = '{breech: 1'b0, injector: 1'b0, fan: 1'b0, loader: 1'b0};

endpackage

`default_nettype wire

FILE: design/rms_item_if.sv
`default_nettype none

interface rms_item_if #(
    parameter int SENSOR_WIDTH = rms_pkg::SENSOR_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [rms_pkg::KIND_W-1:0]      kind;
    logic                            rev_switch;
    logic                            fwd_switch;
    logic                            overload;
    logic                            no_ammo;
    logic [SENSOR_WIDTH-1:0]         receiver_pressure;
    logic [SENSOR_WIDTH-1:0]         battery_voltage;
    logic signed [rms_pkg::INJ_W-1:0] injection_ms;

    modport source (
        output valid, kind, rev_switch, fwd_switch, overload, no_ammo,
               receiver_pressure, battery_voltage, injection_ms,
        input  ready
    );

    modport sink (
        input  valid, kind, rev_switch, fwd_switch, overload, no_ammo,
               receiver_pressure, battery_voltage, injection_ms,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/rms_result_if.sv
`default_nettype none

interface rms_result_if;
    logic                         valid;
    logic                         ready;
    logic [rms_pkg::STATUS_W-1:0] status;
    logic [rms_pkg::ERR_W-1:0]    error_code;
    logic                         loader_reverse;
    logic                         fan_on;
    logic                         injector_on;
    logic                         breech_close;

    modport source (
        output valid, status, error_code, loader_reverse, fan_on, injector_on,
               breech_close,
        input  ready
    );

    modport sink (
        input  valid, status, error_code, loader_reverse, fan_on, injector_on,
               breech_close,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/rms_cfg_if.sv
`default_nettype none

interface rms_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rms_pkg::CFG_IDX_W-1:0]  index;
    logic [rms_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/reverse_mix_sequencer_unit.sv
// Loader-reverse and forced-mixing sequencer.
// Channels: item (sink) carries tick, start and abort items with the switch,
// sensor and injection-time fields; result (source) returns one status item
// per accepted item; cfg (sink) writes the eight timing and threshold
// registers by index and is always ready.
// Output: an item's result is on the result channel in the cycle after its
// transfer. Throughput: one item per cycle unless the result register stalls,
// set by the single pass of sequencing logic from state to result register.
// Timers count one per tick item and saturate at TIME_WIDTH bits.
// Reset: sequencer back to idle, all actuators off, registers to their
// defaults, result register empty.
// Stall: a waiting result holds its register; a new item is still taken in
// the cycle the receiver takes the waiting one, otherwise item.ready is low
// until the result register frees.
`default_nettype none

module reverse_mix_sequencer_unit #(
    parameter int TIME_WIDTH   = rms_pkg::TIME_WIDTH_DEF,
    parameter int SENSOR_WIDTH = rms_pkg::SENSOR_WIDTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rms_item_if.sink      item,
    rms_result_if.source  result,
    rms_cfg_if.sink       cfg
);
    import rms_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > CFG_TIME_W) ? TIME_WIDTH : CFG_TIME_W;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_REVERSE,
        PH_MIXING,
        PH_DONE,
        PH_ERROR
    } phase_t;

    // Configuration registers
    logic [CFG_TIME_W-1:0]   reverse_timeout_reg;
    logic [CFG_TIME_W-1:0]   fan_spinup_reg;
    logic [CFG_TIME_W-1:0]   max_injection_reg;
    logic [CFG_TIME_W-1:0]   mix_fan_reg;
    logic [CFG_TIME_W-1:0]   breech_engage_reg;
    logic [SENSOR_WIDTH-1:0] pressure_min_reg;
    logic [SENSOR_WIDTH-1:0] pressure_max_reg;
    logic [SENSOR_WIDTH-1:0] voltage_min_reg;

    // Sequencer state
    phase_t                phase_reg, phase_next;
    logic [TIME_WIDTH-1:0] phase_timer_reg, phase_timer_next;
    logic [TIME_WIDTH-1:0] fan_timer_reg, fan_timer_next;
    logic [INJ_W-1:0]      inj_left_reg, inj_left_next;
    logic                  injected_reg, injected_next;
    logic                  mixed_reg, mixed_next;
    logic [ERR_W-1:0]      last_error_reg, last_error_next;
    act_t                  act_reg, act_next;

    // Result register
    logic                  res_valid_reg;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [ERR_W-1:0]      res_error_reg, res_error_next;
    act_t                  res_act_reg;

    logic                  item_xfer;
    logic                  cfg_xfer;
    logic [TIME_WIDTH-1:0] pt_inc;
    logic [TIME_WIDTH-1:0] ft_inc;
    logic                  inj_bad;

    assign item.ready = !res_valid_reg || result.ready;
    assign item_xfer  = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign cfg_xfer   = cfg.valid;

    // Saturating timer increments
    assign pt_inc = (phase_timer_reg == TIME_MAX) ? phase_timer_reg : phase_timer_reg + 1'b1;
    assign ft_inc = (fan_timer_reg == TIME_MAX) ? fan_timer_reg : fan_timer_reg + 1'b1;

    // Requested injection must be positive and within the limit
    assign inj_bad = item.injection_ms[INJ_W-1] || (item.injection_ms == '0)
                     || ($unsigned(item.injection_ms) > max_injection_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_timeout_reg <= RST_REVERSE_TIMEOUT;
            fan_spinup_reg      <= RST_FAN_SPINUP;
            max_injection_reg   <= RST_MAX_INJECTION;
            mix_fan_reg         <= RST_MIX_FAN;
            breech_engage_reg   <= RST_BREECH_ENGAGE;
            pressure_min_reg    <= '0;
            pressure_max_reg    <= '1;
            voltage_min_reg     <= '0;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg.index)
                REG_REVERSE_TIMEOUT: reverse_timeout_reg <= cfg.data[CFG_TIME_W-1:0];
                REG_FAN_SPINUP:      fan_spinup_reg      <= cfg.data[CFG_TIME_W-1:0];
                REG_MAX_INJECTION:   max_injection_reg   <= cfg.data[CFG_TIME_W-1:0];
                REG_MIX_FAN:         mix_fan_reg         <= cfg.data[CFG_TIME_W-1:0];
                REG_BREECH_ENGAGE:   breech_engage_reg   <= cfg.data[CFG_TIME_W-1:0];
                REG_PRESSURE_MIN:    pressure_min_reg    <= cfg.data[SENSOR_WIDTH-1:0];
                REG_PRESSURE_MAX:    pressure_max_reg    <= cfg.data[SENSOR_WIDTH-1:0];
                REG_VOLTAGE_MIN:     voltage_min_reg     <= cfg.data[SENSOR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Next state for one item
    always_comb
    begin
        phase_next       = phase_reg;
        phase_timer_next = phase_timer_reg;
        fan_timer_next   = fan_timer_reg;
        inj_left_next    = inj_left_reg;
        injected_next    = injected_reg;
        mixed_next       = mixed_reg;
        last_error_next  = last_error_reg;
        act_next         = act_reg;

        unique case (item.kind)
            KIND_ABORT:
            begin
                phase_next       = PH_IDLE;
                phase_timer_next = '0;
                fan_timer_next   = '0;
                inj_left_next    = '0;
                injected_next    = 1'b0;
                mixed_next       = 1'b0;
                last_error_next  = ERR_NONE;
                act_next         = ACT_OFF;
            end

            KIND_START:
            begin
                if (phase_reg != PH_REVERSE && phase_reg != PH_MIXING)
                begin
                    phase_next = PH_ERROR;
                    if (!item.rev_switch)
                        last_error_next = ERR_POSITION;
                    else if (item.receiver_pressure < pressure_min_reg)
                        last_error_next = ERR_PRESS_LO;
                    else if (item.receiver_pressure > pressure_max_reg)
                        last_error_next = ERR_PRESS_HI;
                    else if (item.battery_voltage < voltage_min_reg)
                        last_error_next = ERR_VOLTAGE;
                    else if (item.no_ammo)
                        last_error_next = ERR_AMMO;
                    else
                    begin
                        phase_next       = PH_REVERSE;
                        phase_timer_next = '0;
                        fan_timer_next   = '0;
                        inj_left_next    = '0;
                        injected_next    = 1'b0;
                        mixed_next       = 1'b0;
                        last_error_next  = ERR_NONE;
                        act_next.loader  = 1'b1;
                    end
                end
            end

            KIND_TICK:
            begin
                if (phase_reg == PH_REVERSE)
                begin
                    phase_timer_next = pt_inc;
                    if (item.overload)
                    begin
                        act_next        = ACT_OFF;
                        act_next.breech = 1'b1;
                        last_error_next = ERR_OVERLOAD;
                        phase_next      = PH_ERROR;
                    end
                    else if (item.fwd_switch)
                    begin
                        act_next.loader = 1'b0;
                        act_next.fan    = 1'b1;
                        phase_next      = PH_MIXING;
                        fan_timer_next  = '0;
                    end
                    else if (CMP_W'(pt_inc) > CMP_W'(reverse_timeout_reg))
                    begin
                        act_next        = ACT_OFF;
                        act_next.breech = 1'b1;
                        last_error_next = ERR_TIMEOUT;
                        phase_next      = PH_ERROR;
                    end
                end
                else if (phase_reg == PH_MIXING)
                begin
                    fan_timer_next = ft_inc;
                    if (mixed_reg)
                        phase_timer_next = pt_inc;

                    if (inj_left_reg != '0)
                    begin
                        // injector open: count the pulse down only
                        inj_left_next = inj_left_reg - 1'b1;
                        if (inj_left_reg == INJ_W'(1))
                        begin
                            act_next.injector = 1'b0;
                            injected_next     = 1'b1;
                        end
                    end
                    else if (!injected_reg
                             && CMP_W'(ft_inc) >= CMP_W'(fan_spinup_reg))
                    begin
                        if (inj_bad)
                        begin
                            act_next.fan    = 1'b0;
                            last_error_next = ERR_INJECTION;
                            phase_next      = PH_ERROR;
                        end
                        else
                        begin
                            act_next.injector = 1'b1;
                            inj_left_next     = $unsigned(item.injection_ms);
                        end
                    end
                    else if (!mixed_reg && CMP_W'(ft_inc) >= CMP_W'(mix_fan_reg))
                    begin
                        mixed_next       = 1'b1;
                        act_next.fan     = 1'b0;
                        act_next.breech  = 1'b1;
                        phase_timer_next = '0;
                    end
                    else if (mixed_reg && CMP_W'(pt_inc) >= CMP_W'(breech_engage_reg))
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end

            default: ;
        endcase
    end

    // Status from the new phase
    always_comb
    begin
        res_error_next = ERR_NONE;
        unique case (phase_next)
            PH_IDLE:  res_status_next = ST_IDLE;
            PH_DONE:  res_status_next = ST_COMPLETED;
            PH_ERROR:
            begin
                res_status_next = ST_ERROR;
                res_error_next  = last_error_next;
            end
            default:  res_status_next = ST_EXECUTING;
        endcase
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            phase_timer_reg <= '0;
            fan_timer_reg   <= '0;
            inj_left_reg    <= '0;
            injected_reg    <= 1'b0;
            mixed_reg       <= 1'b0;
            last_error_reg  <= ERR_NONE;
            act_reg         <= ACT_OFF;
            res_valid_reg   <= 1'b0;
        end
        else if (item_xfer)
        begin
            phase_reg       <= phase_next;
            phase_timer_reg <= phase_timer_next;
            fan_timer_reg   <= fan_timer_next;
            inj_left_reg    <= inj_left_next;
            injected_reg    <= injected_next;
            mixed_reg       <= mixed_next;
            last_error_reg  <= last_error_next;
            act_reg         <= act_next;
            res_valid_reg   <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            res_status_reg <= res_status_next;
            res_error_reg  <= res_error_next;
            res_act_reg    <= act_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.status         = res_status_reg;
    assign result.error_code     = res_error_reg;
    assign result.loader_reverse = res_act_reg.loader;
    assign result.fan_on         = res_act_reg.fan;
    assign result.injector_on    = res_act_reg.injector;
    assign result.breech_close   = res_act_reg.breech;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rms_pkg::*;

    localparam int SENSOR_W = SENSOR_WIDTH_DEF;

    // Kind code the block leaves undecoded
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // One sensor/command item, laid out in the same order as the channel fields
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                rev_sw;
        logic                fwd_sw;
        logic                ovl;
        logic                empty_mag;
        logic [SENSOR_W-1:0] pres;
        logic [SENSOR_W-1:0] volt;
        logic [INJ_W-1:0]    inj_ms;
    } sensor_item_t;

    // One status report, same order as the result channel fields
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ERR_W-1:0]    err;
        logic                loader;
        logic                fan;
        logic                injector;
        logic                breech;
    } seq_result_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_REVERSE,
        SEQ_MIXING,
        SEQ_DONE,
        SEQ_FAULT
    } seq_phase_e;

    typedef enum {
        PLAN_DIRECTED,
        PLAN_TIGHT,
        PLAN_FLOOR,
        PLAN_CEILING,
        PLAN_DEFAULT
    } plan_mode_e;

    logic clk = 1'b0;
    logic rst_n;

    rms_item_if #(.SENSOR_WIDTH(SENSOR_W)) item_ch ();
    rms_result_if                          result_ch ();
    rms_cfg_if                             cfg_ch ();

    reverse_mix_sequencer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #1 clk = ~clk;

    // Sequencer state as predicted
    seq_phase_e          seq_ph;
    logic [15:0]         seq_phase_tmr;
    logic [15:0]         seq_fan_tmr;
    logic [15:0]         seq_inj_left;
    logic                seq_injected;
    logic                seq_mixed;
    logic [ERR_W-1:0]    seq_err;
    act_t                seq_act;

    // Register copies as written into the block
    logic [15:0]         rev_timeout;
    logic [15:0]         spinup;
    logic [15:0]         max_inj;
    logic [15:0]         mix_fan;
    logic [15:0]         engage;
    logic [SENSOR_W-1:0] press_lo;
    logic [SENSOR_W-1:0] press_hi;
    logic [SENSOR_W-1:0] volt_lo;

    // Register values the stimulus is built for
    logic [15:0]         plan [8];

    sensor_item_t        pending_items [$];
    seq_result_t         expected_reports [$];
    sensor_item_t        on_wire;

    int unsigned         idle_pct;
    int                  src_hold;
    int                  snk_hold;
    int                  items_sent;
    int                  reports_seen;
    int                  mismatches;
    int                  completions_seen;
    int                  faults_seen;
    int                  settings_used;

    plan_mode_e phase_modes [8] = '{PLAN_TIGHT, PLAN_FLOOR, PLAN_TIGHT, PLAN_CEILING,
                                    PLAN_TIGHT, PLAN_DEFAULT, PLAN_TIGHT, PLAN_TIGHT};

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic [15:0] sat_count(input logic [15:0] t);
        return (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

    task automatic clear_sequencer();
        seq_ph        = SEQ_IDLE;
        seq_phase_tmr = '0;
        seq_fan_tmr   = '0;
        seq_inj_left  = '0;
        seq_injected  = 1'b0;
        seq_mixed     = 1'b0;
        seq_err       = ERR_NONE;
        seq_act       = ACT_OFF;
    endtask

    task automatic raise_fault(input logic [ERR_W-1:0] code);
        seq_err = code;
        seq_ph  = SEQ_FAULT;
    endtask

    // Advance the predicted sequencer by one item and form its report
    task automatic step_sequencer(input sensor_item_t it, output seq_result_t rep);
        logic signed [15:0] req;
        req = $signed(it.inj_ms);
        if (it.kind == KIND_ABORT)
            clear_sequencer();
        else if (it.kind == KIND_START)
        begin
            // start while executing is ignored
            if (seq_ph != SEQ_REVERSE && seq_ph != SEQ_MIXING)
            begin
                if (!it.rev_sw)
                    raise_fault(ERR_POSITION);
                else if (it.pres < press_lo)
                    raise_fault(ERR_PRESS_LO);
                else if (it.pres > press_hi)
                    raise_fault(ERR_PRESS_HI);
                else if (it.volt < volt_lo)
                    raise_fault(ERR_VOLTAGE);
                else if (it.empty_mag)
                    raise_fault(ERR_AMMO);
                else
                begin
                    seq_ph         = SEQ_REVERSE;
                    seq_phase_tmr  = '0;
                    seq_fan_tmr    = '0;
                    seq_inj_left   = '0;
                    seq_injected   = 1'b0;
                    seq_mixed      = 1'b0;
                    seq_err        = ERR_NONE;
                    seq_act.loader = 1'b1;
                end
            end
        end
        else if (it.kind == KIND_TICK)
        begin
            if (seq_ph == SEQ_REVERSE)
            begin
                seq_phase_tmr = sat_count(seq_phase_tmr);
                if (it.ovl)
                begin
                    seq_act        = ACT_OFF;
                    seq_act.breech = 1'b1;
                    raise_fault(ERR_OVERLOAD);
                end
                else if (it.fwd_sw)
                begin
                    seq_act.loader = 1'b0;
                    seq_act.fan    = 1'b1;
                    seq_ph         = SEQ_MIXING;
                    seq_fan_tmr    = '0;
                end
                else if (seq_phase_tmr > rev_timeout)
                begin
                    seq_act        = ACT_OFF;
                    seq_act.breech = 1'b1;
                    raise_fault(ERR_TIMEOUT);
                end
            end
            else if (seq_ph == SEQ_MIXING)
            begin
                seq_fan_tmr = sat_count(seq_fan_tmr);
                if (seq_mixed)
                    seq_phase_tmr = sat_count(seq_phase_tmr);
                // open injector only counts down
                if (seq_inj_left != 0)
                begin
                    seq_inj_left = seq_inj_left - 16'd1;
                    if (seq_inj_left == 0)
                    begin
                        seq_act.injector = 1'b0;
                        seq_injected     = 1'b1;
                    end
                end
                else if (!seq_injected && seq_fan_tmr >= spinup)
                begin
                    if (req <= 0 || $unsigned(req) > max_inj)
                    begin
                        seq_act.fan = 1'b0;
                        raise_fault(ERR_INJECTION);
                    end
                    else
                    begin
                        seq_act.injector = 1'b1;
                        seq_inj_left     = $unsigned(req);
                    end
                end
                else if (!seq_mixed && seq_fan_tmr >= mix_fan)
                begin
                    seq_mixed      = 1'b1;
                    seq_act.fan    = 1'b0;
                    seq_act.breech = 1'b1;
                    seq_phase_tmr  = '0;
                end
                else if (seq_mixed && seq_phase_tmr >= engage)
                    seq_ph = SEQ_DONE;
            end
        end

        case (seq_ph)
            SEQ_IDLE:  rep.status = ST_IDLE;
            SEQ_DONE:  rep.status = ST_COMPLETED;
            SEQ_FAULT: rep.status = ST_ERROR;
            default:   rep.status = ST_EXECUTING;
        endcase
        rep.err      = (seq_ph == SEQ_FAULT) ? seq_err : ERR_NONE;
        rep.loader   = seq_act.loader;
        rep.fan      = seq_act.fan;
        rep.injector = seq_act.injector;
        rep.breech   = seq_act.breech;
    endtask

    // Item builders
    function automatic sensor_item_t noise_item();
        sensor_item_t it;
        it.kind      = KIND_W'($urandom_range(0, 3));
        it.rev_sw    = 1'($urandom_range(0, 1));
        it.fwd_sw    = 1'($urandom_range(0, 1));
        it.ovl       = 1'($urandom_range(0, 1));
        it.empty_mag = 1'($urandom_range(0, 1));
        it.pres      = SENSOR_W'($urandom);
        it.volt      = SENSOR_W'($urandom);
        it.inj_ms    = INJ_W'($urandom);
        // lean on the field extremes now and then
        case ($urandom_range(0, 7))
            0: it.pres = '0;
            1: it.pres = '1;
            2: it.volt = '0;
            3: it.volt = '1;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: it.inj_ms = 16'h7FFF;
            1: it.inj_ms = 16'h8000;
            2: it.inj_ms = 16'hFFFF;
            3: it.inj_ms = 16'h0000;
            default: ;
        endcase
        return it;
    endfunction

    function automatic sensor_item_t kind_item(input logic [KIND_W-1:0] k);
        sensor_item_t it;
        it      = noise_item();
        it.kind = k;
        return it;
    endfunction

    function automatic sensor_item_t tick_item(input logic fwd, input logic ovl,
                                               input logic [INJ_W-1:0] inj);
        sensor_item_t it;
        it        = kind_item(KIND_TICK);
        it.fwd_sw = fwd;
        it.ovl    = ovl;
        it.inj_ms = inj;
        return it;
    endfunction

    function automatic sensor_item_t start_with(input logic rev, input logic [SENSOR_W-1:0] p,
                                                input logic [SENSOR_W-1:0] v, input logic ammo);
        sensor_item_t it;
        it           = kind_item(KIND_START);
        it.rev_sw    = rev;
        it.pres      = p;
        it.volt      = v;
        it.empty_mag = ammo;
        return it;
    endfunction

    // Start that passes every precondition under the planned registers, unless the planned pressure range is empty
    function automatic sensor_item_t good_start();
        logic [SENSOR_W-1:0] plo, phi, vlo, p, v;
        plo = plan[REG_PRESSURE_MIN][SENSOR_W-1:0];
        phi = plan[REG_PRESSURE_MAX][SENSOR_W-1:0];
        vlo = plan[REG_VOLTAGE_MIN][SENSOR_W-1:0];
        if (plo <= phi)
            p = SENSOR_W'($urandom_range(plo, phi));
        else
            p = SENSOR_W'($urandom);
        v = SENSOR_W'($urandom_range(vlo, (1 << SENSOR_W) - 1));
        case ($urandom_range(0, 5))
            0: p = plo;
            1: p = (plo <= phi) ? phi : plo;
            2: v = vlo;
            default: ;
        endcase
        return start_with(1'b1, p, v, 1'b0);
    endfunction

    // One action: start and reverse, then mixing and some tail traffic unless the reverse faults
    task automatic queue_action();
        int unsigned n_rev, n_mix, roll, lim, rev_to, mx;
        logic [INJ_W-1:0] inj_req;
        rev_to = plan[REG_REVERSE_TIMEOUT];
        mx     = plan[REG_MAX_INJECTION];
        pending_items.push_back(good_start());
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            // overload part way through the reverse
            repeat ($urandom_range(0, 3))
                pending_items.push_back(tick_item(1'b0, 1'b0, INJ_W'($urandom)));
            pending_items.push_back(tick_item(1'($urandom_range(0, 1)), 1'b1,
                                              INJ_W'($urandom)));
            return;
        end
        if (roll == 1 && rev_to <= 40)
        begin
            // forward switch never closes
            repeat (rev_to + 1)
                pending_items.push_back(tick_item(1'b0, 1'b0, INJ_W'($urandom)));
            return;
        end
        n_rev = $urandom_range(0, (rev_to < 8) ? rev_to : 8);
        repeat (n_rev)
            pending_items.push_back(tick_item(1'b0, 1'b0, INJ_W'($urandom)));
        pending_items.push_back(tick_item(1'b1, 1'b0, INJ_W'($urandom)));

        // injection request: mostly valid, sometimes out of range
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 2))
                0: inj_req = '0;
                1: inj_req = 16'h8000 | INJ_W'($urandom);
                default: inj_req = (mx < 32767) ? INJ_W'(mx + 1) : 16'h8000;
            endcase
        end
        else
            inj_req = INJ_W'($urandom_range(1, (mx < 8) ? mx : 8));

        lim = plan[REG_FAN_SPINUP] + inj_req + plan[REG_MIX_FAN] + plan[REG_BREECH_ENGAGE] + 4;
        if (lim > 80)
            n_mix = $urandom_range(10, 60);
        else
            n_mix = $urandom_range(lim - 2, lim + 2);
        repeat (n_mix)
            pending_items.push_back(tick_item(1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1)), inj_req));
        if (n_mix < lim && $urandom_range(0, 9) < 7)
            pending_items.push_back(kind_item(KIND_ABORT));

        case ($urandom_range(0, 5))
            0: pending_items.push_back(kind_item(KIND_ABORT));
            1: pending_items.push_back(noise_item());
            2: repeat ($urandom_range(1, 3))
                   pending_items.push_back(kind_item(KIND_TICK));
            3: pending_items.push_back(start_with(1'b0, SENSOR_W'($urandom),
                                                  SENSOR_W'($urandom), 1'($urandom)));
            default: ;
        endcase
    endtask

    task automatic queue_phase(input int count);
        while (pending_items.size() < count)
        begin
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 3))
                    pending_items.push_back(noise_item());
            else
                queue_action();
        end
    endtask

    task automatic choose_plan(input plan_mode_e mode);
        case (mode)
            PLAN_DIRECTED:
            begin
                plan[REG_REVERSE_TIMEOUT] = 16'd3;
                plan[REG_FAN_SPINUP]      = 16'd2;
                plan[REG_MAX_INJECTION]   = 16'd3;
                plan[REG_MIX_FAN]         = 16'd8;
                plan[REG_BREECH_ENGAGE]   = 16'd2;
                plan[REG_PRESSURE_MIN]    = 16'd100;
                plan[REG_PRESSURE_MAX]    = 16'd900;
                plan[REG_VOLTAGE_MIN]     = 16'd200;
            end
            PLAN_FLOOR:
            begin
                plan[REG_REVERSE_TIMEOUT] = 16'd0;
                plan[REG_FAN_SPINUP]      = 16'd0;
                plan[REG_MAX_INJECTION]   = 16'd1;
                plan[REG_MIX_FAN]         = 16'd0;
                plan[REG_BREECH_ENGAGE]   = 16'd0;
                plan[REG_PRESSURE_MIN]    = 16'd0;
                plan[REG_PRESSURE_MAX]    = 16'd0;
                plan[REG_VOLTAGE_MIN]     = 16'd0;
            end
            PLAN_CEILING:
            begin
                plan[REG_REVERSE_TIMEOUT] = 16'hFFFF;
                plan[REG_FAN_SPINUP]      = 16'hFFFF;
                plan[REG_MAX_INJECTION]   = 16'hFFFF;
                plan[REG_MIX_FAN]         = 16'hFFFF;
                plan[REG_BREECH_ENGAGE]   = 16'hFFFF;
                plan[REG_PRESSURE_MIN]    = 16'd1023;
                plan[REG_PRESSURE_MAX]    = 16'd1023;
                plan[REG_VOLTAGE_MIN]     = 16'd1023;
            end
            PLAN_DEFAULT:
            begin
                plan[REG_REVERSE_TIMEOUT] = RST_REVERSE_TIMEOUT;
                plan[REG_FAN_SPINUP]      = RST_FAN_SPINUP;
                plan[REG_MAX_INJECTION]   = RST_MAX_INJECTION;
                plan[REG_MIX_FAN]         = RST_MIX_FAN;
                plan[REG_BREECH_ENGAGE]   = RST_BREECH_ENGAGE;
                plan[REG_PRESSURE_MIN]    = 16'd0;
                plan[REG_PRESSURE_MAX]    = 16'd1023;
                plan[REG_VOLTAGE_MIN]     = 16'd0;
            end
            default:
            begin
                // short timings so whole actions fit in a phase
                plan[REG_REVERSE_TIMEOUT] = 16'($urandom_range(0, 12));
                plan[REG_FAN_SPINUP]      = 16'($urandom_range(0, 6));
                plan[REG_MAX_INJECTION]   = 16'($urandom_range(1, 6));
                plan[REG_MIX_FAN]         = 16'($urandom_range(0, 25));
                plan[REG_BREECH_ENGAGE]   = 16'($urandom_range(0, 6));
                if ($urandom_range(0, 5) == 0)
                begin
                    plan[REG_PRESSURE_MIN] = 16'($urandom_range(0, 1023));
                    plan[REG_PRESSURE_MAX] = 16'($urandom_range(0, 1023));
                end
                else
                begin
                    plan[REG_PRESSURE_MIN] = 16'($urandom_range(0, 400));
                    plan[REG_PRESSURE_MAX] = 16'($urandom_range(500, 1023));
                end
                plan[REG_VOLTAGE_MIN]     = 16'($urandom_range(0, 500));
            end
        endcase
    endtask

    // Write every register from the plan; the caller has just waited on posedge clk
    task automatic program_registers();
        for (int i = 0; i <= REG_VOLTAGE_MIN; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= CFG_IDX_W'(i);
            cfg_ch.data  <= plan[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Wait until every item is out and every report is back, then let the pipe settle
    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Item driver and predictor: tracks register writes and predicts each transfer
    always @(posedge clk or negedge rst_n)
    begin
        sensor_item_t sent;
        seq_result_t  pred;
        logic         drive_valid;
        if (!rst_n)
        begin
            clear_sequencer();
            rev_timeout = RST_REVERSE_TIMEOUT;
            spinup      = RST_FAN_SPINUP;
            max_inj     = RST_MAX_INJECTION;
            mix_fan     = RST_MIX_FAN;
            engage      = RST_BREECH_ENGAGE;
            press_lo    = '0;
            press_hi    = '1;
            volt_lo     = '0;
            on_wire     = '0;
            src_hold    <= 0;
            item_ch.valid <= 1'b0;
            {item_ch.kind, item_ch.rev_switch, item_ch.fwd_switch, item_ch.overload,
             item_ch.no_ammo, item_ch.receiver_pressure, item_ch.battery_voltage,
             item_ch.injection_ms} <= '0;
        end
        else
        begin
            // register write transfer
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_REVERSE_TIMEOUT: rev_timeout = cfg_ch.data;
                    REG_FAN_SPINUP:      spinup      = cfg_ch.data;
                    REG_MAX_INJECTION:   max_inj     = cfg_ch.data;
                    REG_MIX_FAN:         mix_fan     = cfg_ch.data;
                    REG_BREECH_ENGAGE:   engage      = cfg_ch.data;
                    REG_PRESSURE_MIN:    press_lo    = cfg_ch.data[SENSOR_W-1:0];
                    REG_PRESSURE_MAX:    press_hi    = cfg_ch.data[SENSOR_W-1:0];
                    REG_VOLTAGE_MIN:     volt_lo     = cfg_ch.data[SENSOR_W-1:0];
                    default: ;
                endcase
            end

            // item transfer
            if (item_ch.valid && item_ch.ready)
            begin
                sent = pending_items.pop_front();
                step_sequencer(sent, pred);
                expected_reports.push_back(pred);
                items_sent++;
            end

            // next cycle: hold, idle burst, or present the next item
            if (item_ch.valid && !item_ch.ready)
                drive_valid = 1'b1;
            else if (src_hold != 0)
            begin
                drive_valid = 1'b0;
                src_hold    <= src_hold - 1;
            end
            else if (pending_items.size() != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                drive_valid = 1'b0;
                src_hold    <= $urandom_range(0, 7);
            end
            else if (pending_items.size() != 0)
            begin
                drive_valid = 1'b1;
                on_wire     = pending_items[0];
            end
            else
                drive_valid = 1'b0;

            item_ch.valid <= drive_valid;
            {item_ch.kind, item_ch.rev_switch, item_ch.fwd_switch, item_ch.overload,
             item_ch.no_ammo, item_ch.receiver_pressure, item_ch.battery_voltage,
             item_ch.injection_ms} <= on_wire;
        end
    end

    // Report monitor: checks each transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        seq_result_t got;
        seq_result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            snk_hold        <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = {result_ch.status, result_ch.error_code, result_ch.loader_reverse,
                       result_ch.fan_on, result_ch.injector_on, result_ch.breech_close};
                if (expected_reports.size() == 0)
                    note_mismatch("report arrived with no item outstanding");
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.status !== want.status)
                        note_mismatch($sformatf("report %0d status %0d, predicted %0d",
                                                reports_seen, got.status, want.status));
                    if (got.err !== want.err)
                        note_mismatch($sformatf("report %0d error_code %0d, predicted %0d",
                                                reports_seen, got.err, want.err));
                    if (got.loader !== want.loader)
                        note_mismatch($sformatf("report %0d loader_reverse %b, predicted %b",
                                                reports_seen, got.loader, want.loader));
                    if (got.fan !== want.fan)
                        note_mismatch($sformatf("report %0d fan_on %b, predicted %b",
                                                reports_seen, got.fan, want.fan));
                    if (got.injector !== want.injector)
                        note_mismatch($sformatf("report %0d injector_on %b, predicted %b",
                                                reports_seen, got.injector, want.injector));
                    if (got.breech !== want.breech)
                        note_mismatch($sformatf("report %0d breech_close %b, predicted %b",
                                                reports_seen, got.breech, want.breech));
                    if (want.status == ST_COMPLETED)
                        completions_seen++;
                    if (want.status == ST_ERROR)
                        faults_seen++;
                end
                reports_seen++;
            end

            // receiver stalls in bursts
            if (snk_hold != 0)
            begin
                result_ch.ready <= 1'b0;
                snk_hold        <= snk_hold - 1;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                result_ch.ready <= 1'b0;
                snk_hold        <= $urandom_range(0, 7);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Stimulus and phase control
    initial
    begin
        sensor_item_t it;
        idle_pct = 20;
        rst_n    = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        result_ch.ready = 1'b0;
        item_ch.valid   = 1'b0;
        {item_ch.kind, item_ch.rev_switch, item_ch.fwd_switch, item_ch.overload,
         item_ch.no_ammo, item_ch.receiver_pressure, item_ch.battery_voltage,
         item_ch.injection_ms} = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each precondition failure, ignored start, reverse and injection faults
        choose_plan(PLAN_DIRECTED);
        program_registers();
        pending_items.push_back(kind_item(KIND_SPARE));
        pending_items.push_back(start_with(1'b0, 10'd500, 10'd500, 1'b0));
        pending_items.push_back(start_with(1'b1, 10'd99, 10'd500, 1'b0));
        pending_items.push_back(start_with(1'b1, 10'd901, 10'd500, 1'b0));
        pending_items.push_back(start_with(1'b1, 10'd500, 10'd199, 1'b0));
        pending_items.push_back(start_with(1'b1, 10'd500, 10'd500, 1'b1));
        pending_items.push_back(start_with(1'b1, 10'd100, 10'd200, 1'b0));
        pending_items.push_back(start_with(1'b1, 10'd500, 10'd500, 1'b0));
        // overload wins over a closed forward switch
        pending_items.push_back(tick_item(1'b1, 1'b1, 16'd0));
        pending_items.push_back(start_with(1'b1, 10'd900, 10'd1023, 1'b0));
        pending_items.push_back(kind_item(KIND_ABORT));
        pending_items.push_back(start_with(1'b1, 10'd500, 10'd500, 1'b0));
        repeat (4)
            pending_items.push_back(tick_item(1'b0, 1'b0, 16'd0));
        // most negative and most positive injection requests
        pending_items.push_back(start_with(1'b1, 10'd500, 10'd500, 1'b0));
        pending_items.push_back(tick_item(1'b1, 1'b0, 16'd0));
        repeat (2)
            pending_items.push_back(tick_item(1'b0, 1'b0, 16'h8000));
        pending_items.push_back(start_with(1'b1, 10'd500, 10'd500, 1'b0));
        pending_items.push_back(tick_item(1'b1, 1'b0, 16'd0));
        repeat (2)
            pending_items.push_back(tick_item(1'b0, 1'b0, 16'h7FFF));
        wait_drained();

        // Random phases, one register setting each; the last runs without stalls
        foreach (phase_modes[k])
        begin
            choose_plan(phase_modes[k]);
            program_registers();
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 35;
            endcase
            if (k == $size(phase_modes) - 1)
                idle_pct = 0;
            queue_phase(75);
            wait_drained();
        end

        $display("Sent %0d items under %0d register settings; %0d reports checked.",
                 items_sent, settings_used, reports_seen);
        $display("Reports showing completion: %0d, showing an error: %0d, mismatches: %0d.",
                 completions_seen, faults_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("Watchdog expired with %0d items queued and %0d reports outstanding.",
                 pending_items.size(), expected_reports.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
